>>> design/spgm_pkg.sv
// Shared constants, types and the quarter-sine table of the smoothed pan gain meter.
`timescale 1ns / 1ps

package spgm_pkg;

	// Sample and table geometry.
	localparam int SAMPLE_WIDTH    = 24;
	localparam int SINE_TABLE_SIZE = 256;
	localparam int TAB_BITS        = $clog2(SINE_TABLE_SIZE);
	localparam int IDX_W           = TAB_BITS + 1;
	localparam int PEAK_W          = SAMPLE_WIDTH - 1;

	// Gain and arithmetic widths.
	localparam int GAIN_W    = 32;
	localparam int GAIN_FRAC = 30;
	localparam int COEF_W    = 17;
	localparam int MUL_B_W   = (SAMPLE_WIDTH > COEF_W) ? SAMPLE_WIDTH : COEF_W;
	localparam int PROD_W    = GAIN_W + MUL_B_W;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COEF_W;

	localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MUTED  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO = 3'd4;

	localparam logic [15:0]       VOLUME_RST = 16'd16384;
	localparam logic [COEF_W-1:0] COEFF_RST  = 17'd273;
	localparam logic [COEF_W-1:0] COEFF_ONE  = 17'd65536;

	// Operand selection of the shared multiplier.
	localparam logic [1:0] MUL_INTERP = 2'd0;
	localparam logic [1:0] MUL_VOL    = 2'd1;
	localparam logic [1:0] MUL_SMOOTH = 2'd2;
	localparam logic [1:0] MUL_APPLY  = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] left_in;
		logic signed [SAMPLE_WIDTH-1:0] right_in;
		logic                           last_in_block;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] left_out;
		logic signed [SAMPLE_WIDTH-1:0] right_out;
		logic        [PEAK_W-1:0]       peak_level;
		logic                           block_done;
	} result_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic       load_frame;
		logic       lut;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       pan_gain;
		logic       target;
		logic       diff;
		logic       smooth;
		logic       apply;
		logic       finish;
		logic       ch;
	} dp_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic stereo;
	} dp_sts_t;

	typedef logic [15:0] sine_tab_t [0:SINE_TABLE_SIZE];

	// sin(pi/2 * k / SINE_TABLE_SIZE) in Q1.15, by a Q30 Taylor series.
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t   tab;
		logic [63:0] theta;
		logic [63:0] theta2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] prod;
		for (int k = 0; k <= SINE_TABLE_SIZE; k++) begin
			theta  = (64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_SIZE / 2)) / SINE_TABLE_SIZE;
			theta2 = (theta * theta + (64'd1 << 29)) >> 30;
			term   = theta;
			sum    = theta;
			for (int n = 1; n <= 10; n++) begin
				prod = (term * theta2) >> 30;
				// Each term divides by (2n)(2n+1), the next two factors of the factorial.
				case (n)
					1:       term = prod / 64'd6;
					2:       term = prod / 64'd20;
					3:       term = prod / 64'd42;
					4:       term = prod / 64'd72;
					5:       term = prod / 64'd110;
					6:       term = prod / 64'd156;
					7:       term = prod / 64'd210;
					8:       term = prod / 64'd272;
					9:       term = prod / 64'd342;
					default: term = prod / 64'd420;
				endcase
				if (n[0]) begin
					sum = (term > sum) ? 64'd0 : sum - term;
				end else begin
					sum = sum + term;
				end
			end
			sum    = (sum + (64'd1 << 14)) >> 15;
			tab[k] = (sum > 64'd32768) ? 16'd32768 : sum[15:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

>>> design/spgm_ctrl.sv
// Sequencer of the smoothed pan gain meter: walks each frame through the shared datapath.
`timescale 1ns / 1ps

module spgm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             frame_valid,
	output logic             frame_stall,
	output logic             result_valid,
	input  logic             result_stall,
	input  spgm_pkg::dp_sts_t sts,
	output spgm_pkg::dp_cmd_t cmd
);
	import spgm_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LUT  = 4'd1;
	localparam logic [3:0] ST_INT  = 4'd2;
	localparam logic [3:0] ST_PG   = 4'd3;
	localparam logic [3:0] ST_VMUL = 4'd4;
	localparam logic [3:0] ST_TGT  = 4'd5;
	localparam logic [3:0] ST_DIF  = 4'd6;
	localparam logic [3:0] ST_SMUL = 4'd7;
	localparam logic [3:0] ST_SUPD = 4'd8;
	localparam logic [3:0] ST_AMUL = 4'd9;
	localparam logic [3:0] ST_APP  = 4'd10;
	localparam logic [3:0] ST_FIN  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       ch_q;
	logic       valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (frame_valid) begin
					cmd.load_frame = 1'b1;
					state_nxt      = sts.stereo ? ST_LUT : ST_TGT;
				end
			end
			ST_LUT: begin
				cmd.lut   = 1'b1;
				state_nxt = ST_INT;
			end
			ST_INT: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_INTERP;
				state_nxt   = ST_PG;
			end
			ST_PG: begin
				cmd.pan_gain = 1'b1;
				state_nxt    = ST_VMUL;
			end
			ST_VMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_VOL;
				state_nxt   = ST_TGT;
			end
			ST_TGT: begin
				cmd.target = 1'b1;
				state_nxt  = ST_DIF;
			end
			ST_DIF: begin
				cmd.diff  = 1'b1;
				state_nxt = ST_SMUL;
			end
			ST_SMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SMOOTH;
				state_nxt   = ST_SUPD;
			end
			ST_SUPD: begin
				cmd.smooth = 1'b1;
				state_nxt  = ST_AMUL;
			end
			ST_AMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_APPLY;
				state_nxt   = ST_APP;
			end
			ST_APP: begin
				cmd.apply = 1'b1;
				state_nxt = (sts.stereo && !ch_q) ? ST_LUT : ST_FIN;
			end
			ST_FIN: begin
				if (!valid_q || !result_stall) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
		cmd.ch = ch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_frame) begin
				ch_q <= 1'b0;
			end else if (cmd.apply && sts.stereo && !ch_q) begin
				ch_q <= 1'b1;
			end
			if (cmd.finish) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign frame_stall  = (state_q != ST_IDLE);
	assign result_valid = valid_q;

endmodule

>>> design/spgm_datapath.sv
// Datapath of the smoothed pan gain meter: registers, pan table, smoothers, shared multiplier.
`timescale 1ns / 1ps

module spgm_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spgm_pkg::dp_cmd_t                   cmd,
	output spgm_pkg::dp_sts_t                   sts,
	input  spgm_pkg::frame_t                    frame,
	input  logic                                cfg_we,
	input  logic [spgm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spgm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output spgm_pkg::result_t                   result
);
	import spgm_pkg::*;

	localparam int SW  = SAMPLE_WIDTH;
	localparam int R_W = PROD_W - GAIN_FRAC;
	localparam logic [R_W-1:0] R_POS_MAX = R_W'((64'd1 << (SW - 1)) - 64'd1);
	localparam logic [R_W-1:0] R_NEG_MAX = R_W'(64'd1 << (SW - 1));
	localparam logic [PROD_W-1:0] APPLY_HALF = PROD_W'(64'd1 << (GAIN_FRAC - 1));

	// Configuration registers.
	logic [15:0]        volume_q;
	logic               muted_q;
	logic signed [15:0] pan_q;
	logic [COEF_W-1:0]  coeff_q;
	logic               stereo_q;

	// Per-frame working registers.
	logic signed [SW-1:0] smp_l_q;
	logic signed [SW-1:0] smp_r_q;
	logic                 last_q;
	logic [15:0]          a_q;
	logic [15:0]          diff_q;
	logic [15:0]          frac_q;
	logic [15:0]          pg_q;
	logic [PROD_W-1:0]    prod_q;
	logic [GAIN_W-1:0]    target_q;
	logic [GAIN_W-1:0]    delta_q;
	logic                 up_q;
	logic [SW-1:0]        res_l_q;
	logic [SW-1:0]        res_r_q;
	result_t              result_q;

	// Smoother state and meter.
	logic [GAIN_W-1:0] gain_l_q;
	logic [GAIN_W-1:0] gain_r_q;
	logic              primed_q;
	logic [PEAK_W-1:0] peak_q;

	logic [15:0]        vol_eff;
	logic [COEF_W-1:0]  coeff_eff;
	logic [16:0]        pos_r;
	logic [16:0]        pos_c;
	logic [IDX_W-1:0]   lut_idx;
	logic [15:0]        lut_frac;
	logic [15:0]        lut_a;
	logic [15:0]        lut_b;
	logic [32:0]        interp_sum;
	logic [GAIN_W-1:0]  tgt;
	logic [GAIN_W-1:0]  gain_sel;
	logic [48:0]        smooth_sum;
	logic [GAIN_W-1:0]  step;
	logic [GAIN_W-1:0]  gain_new;
	logic [SW-1:0]      smp_bits;
	logic [SW-1:0]      mag;
	logic [GAIN_W-1:0]  mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  app_sum;
	logic [R_W-1:0]     r_raw;
	logic [R_W-1:0]     r_clip;
	logic [SW-1:0]      res;
	logic [PEAK_W-1:0]  mag_out;

	assign vol_eff   = muted_q ? 16'd0 : volume_q;
	assign coeff_eff = (coeff_q > COEFF_ONE) ? COEFF_ONE : coeff_q;

	// Pan position 0..65535 for the right channel, its mirror for the left.
	assign pos_r    = {1'b0, ~pan_q[15], pan_q[14:0]};
	assign pos_c    = cmd.ch ? pos_r : (17'd65536 - pos_r);
	assign lut_idx  = pos_c[16 -: IDX_W];
	assign lut_frac = {pos_c[15-TAB_BITS:0], {TAB_BITS{1'b0}}};

	always_comb begin
		lut_a = SINE_TAB[SINE_TABLE_SIZE];
		lut_b = SINE_TAB[SINE_TABLE_SIZE];
		if (lut_idx < IDX_W'(SINE_TABLE_SIZE)) begin
			lut_a = SINE_TAB[lut_idx];
			lut_b = SINE_TAB[IDX_W'(lut_idx + 1'b1)];
		end
	end

	assign interp_sum = {1'b0, prod_q[31:0]} + 33'd32768;
	assign tgt = stereo_q ? {prod_q[30:0], 1'b0} : {vol_eff, 16'd0};

	assign gain_sel   = cmd.ch ? gain_r_q : gain_l_q;
	assign smooth_sum = prod_q[48:0] + 49'd32768;
	assign step       = smooth_sum[47:16];
	assign gain_new   = up_q ? (gain_sel + step) : (gain_sel - step);

	assign smp_bits = cmd.ch ? smp_r_q : smp_l_q;
	assign mag      = smp_bits[SW-1] ? (~smp_bits + 1'b1) : smp_bits;

	// Output rounding, saturation and magnitude for the meter.
	assign app_sum = prod_q + APPLY_HALF;
	assign r_raw   = app_sum[PROD_W-1:GAIN_FRAC];

	always_comb begin
		if (smp_bits[SW-1]) begin
			r_clip  = (r_raw > R_NEG_MAX) ? R_NEG_MAX : r_raw;
			res     = ~r_clip[SW-1:0] + 1'b1;
			mag_out = (r_clip > R_POS_MAX) ? R_POS_MAX[PEAK_W-1:0] : r_clip[PEAK_W-1:0];
		end else begin
			r_clip  = (r_raw > R_POS_MAX) ? R_POS_MAX : r_raw;
			res     = r_clip[SW-1:0];
			mag_out = r_clip[PEAK_W-1:0];
		end
	end

	always_comb begin
		case (cmd.mul_sel)
			MUL_INTERP: begin
				mul_a = GAIN_W'(diff_q);
				mul_b = MUL_B_W'(frac_q);
			end
			MUL_VOL: begin
				mul_a = GAIN_W'(vol_eff);
				mul_b = MUL_B_W'(pg_q);
			end
			MUL_SMOOTH: begin
				mul_a = delta_q;
				mul_b = MUL_B_W'(coeff_eff);
			end
			MUL_APPLY: begin
				mul_a = gain_sel;
				mul_b = MUL_B_W'(mag);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= VOLUME_RST;
			muted_q  <= 1'b0;
			pan_q    <= '0;
			coeff_q  <= COEFF_RST;
			stereo_q <= 1'b1;
			gain_l_q <= '0;
			gain_r_q <= '0;
			primed_q <= 1'b0;
			peak_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VOLUME: volume_q <= cfg_data[15:0];
					REG_MUTED:  muted_q  <= cfg_data[0];
					REG_PAN:    pan_q    <= cfg_data[15:0];
					REG_COEFF:  coeff_q  <= cfg_data;
					REG_STEREO: stereo_q <= cfg_data[0];
					default: ;
				endcase
			end
			// Until the first frame is done, each gain starts at its target.
			if (cmd.target && !primed_q) begin
				if (cmd.ch) begin
					gain_r_q <= tgt;
				end else begin
					gain_l_q <= tgt;
					if (!stereo_q) begin
						gain_r_q <= tgt;
					end
				end
			end
			if (cmd.smooth) begin
				if (cmd.ch) begin
					gain_r_q <= gain_new;
				end else begin
					gain_l_q <= gain_new;
				end
			end
			if (cmd.apply && (mag_out > peak_q)) begin
				peak_q <= mag_out;
			end
			if (cmd.finish) begin
				primed_q <= 1'b1;
				if (last_q) begin
					peak_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_frame) begin
			smp_l_q <= frame.left_in;
			smp_r_q <= frame.right_in;
			last_q  <= frame.last_in_block;
		end
		if (cmd.lut) begin
			a_q    <= lut_a;
			diff_q <= (lut_b > lut_a) ? (lut_b - lut_a) : 16'd0;
			frac_q <= lut_frac;
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (cmd.pan_gain) begin
			pg_q <= a_q + interp_sum[31:16];
		end
		if (cmd.target) begin
			target_q <= tgt;
		end
		if (cmd.diff) begin
			up_q    <= (target_q >= gain_sel);
			delta_q <= (target_q >= gain_sel) ? (target_q - gain_sel) : (gain_sel - target_q);
		end
		if (cmd.apply) begin
			if (cmd.ch) begin
				res_r_q <= res;
			end else begin
				res_l_q <= res;
			end
		end
		if (cmd.finish) begin
			result_q.left_out      <= res_l_q;
			result_q.right_out     <= stereo_q ? res_r_q : '0;
			result_q.peak_level    <= peak_q;
			result_q.block_done    <= last_q;
		end
	end

	assign sts.stereo = stereo_q;
	assign result     = result_q;

endmodule

>>> design/smoothed_pan_gain_meter_unit.sv
// Top level of the smoothed pan gain meter: sequencer, datapath and the port handshakes.
`timescale 1ns / 1ps
// Frames are taken one at a time; the next frame is stalled until the current one is finished.
// In stereo the single shared multiplier serves four products per channel in turn; mono frames
// need two products, for the left channel only.
// A finished result waits in the output register while the next frame is taken in.
// Reset (arst_n low, asynchronous) restores the register defaults, unprimes the smoothers
// and clears the peak meter; no clearing pass follows.
module smoothed_pan_gain_meter_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Frame input channel.
	input  logic                               frame_valid,
	output logic                               frame_stall,
	input  spgm_pkg::frame_t                   frame,
	// Result output channel.
	output logic                               result_valid,
	input  logic                               result_stall,
	output spgm_pkg::result_t                  result,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [spgm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spgm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import spgm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    cfg_we;

	// Register writes must only be issued while the block is idle; the block does not enforce
	// this itself, and the port never holds a beat off.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	// The sequencer takes one frame at a time. For each channel it steps through
	// the pan table lookup and interpolation, the volume product that forms the
	// target gain, the one-pole smoother update and the final gain product with
	// rounding and saturation. Mono frames skip the pan law and the right channel.
	spgm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// The datapath holds the configuration, both smoothed gains, the peak meter
	// and the output register. The meter is cleared when a result beat marked as
	// the end of a block is loaded into the output register.
	spgm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.frame     (frame),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

>>> design/spgm_checker.sv
// Port-level assertions for the smoothed pan gain meter and their bind to the top level.
`timescale 1ns / 1ps

module spgm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               frame_valid,
	input logic                               frame_stall,
	input logic                               result_valid,
	input logic                               result_stall,
	input spgm_pkg::result_t                  result
);
	import spgm_pkg::*;

	logic [1:0]              pend_q;
	logic                    take_in;
	logic                    take_out;
	logic [SAMPLE_WIDTH-1:0] left_bits;
	logic [SAMPLE_WIDTH-1:0] left_abs;
	logic [PEAK_W-1:0]       left_mag;

	assign take_in   = frame_valid & ~frame_stall;
	assign take_out  = result_valid & ~result_stall;
	assign left_bits = result.left_out;
	assign left_abs  = left_bits[SAMPLE_WIDTH-1] ? (~left_bits + 1'b1) : left_bits;
	assign left_mag  = left_abs[SAMPLE_WIDTH-1] ? {PEAK_W{1'b1}} : left_abs[PEAK_W-1:0];

	// Frames taken in and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, take_in} - {1'b0, take_out};
		end
	end

	// A stalled result beat holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// Frames are processed one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> frame_stall)
		else $error("second frame accepted while the first is in work");

	// Every result beat belongs to an accepted frame.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 2'd0)
		else $error("result shown without an accepted frame");

	// The meter covers the left output of the same beat.
	a_peak_covers_left: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.peak_level >= left_mag)
		else $error("peak level below the left output magnitude");

endmodule

bind smoothed_pan_gain_meter_unit spgm_checker u_spgm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.frame_valid  (frame_valid),
	.frame_stall  (frame_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> bench/tb_top.sv
// Self-checking bench for the smoothed pan gain meter, driven by directed and random frames.
`timescale 1ns / 1ps

module tb_top;
	import spgm_pkg::*;

	// Run shape.
	localparam int     RUN_PHASES    = 12;
	localparam int     PHASE_FRAMES  = 50;
	localparam int     CALM_PHASE    = 3;
	localparam int     DRAIN_PHASE   = 6;
	localparam int     IDLE_PCT      = 34;
	localparam int     REPORT_LIMIT  = 10;
	localparam int     SETTLE_CYCLES = 40;
	localparam longint TIMEOUT_NS    = 5_000_000;

	// Fixed-point constants of the gain arithmetic.
	localparam longint unsigned HALF_PI_FIX = 64'd1686629713;
	localparam longint unsigned POS_LIMIT   = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;

	localparam logic signed [SAMPLE_WIDTH-1:0] FULL_POS = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] FULL_NEG = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

	// An index outside the register map; the block must take the write and ignore it.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  frame_valid;
	logic                  frame_stall;
	frame_t                frame;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	smoothed_pan_gain_meter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame        (frame),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Bench copy of the channel strip: its registers, smoother state and peak meter.
	logic [15:0]        quarter_wave [0:SINE_TABLE_SIZE];
	logic [15:0]        set_volume;
	logic               set_muted;
	logic signed [15:0] set_pan;
	logic [COEF_W-1:0]  set_coeff;
	logic               set_stereo;
	logic [31:0]        left_gain;
	logic [31:0]        right_gain;
	logic               gains_primed;
	logic [PEAK_W-1:0]  block_peak;

	// Scaled frames still owed by the block, oldest first.
	result_t scaled_frames_due [$];

	int fail_count = 0;
	// While calm is set neither side idles; this gives one long stretch of back-to-back beats.
	bit calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// Gain arithmetic.
	// ------------------------------------------------------------------

	// One entry of the quarter-sine table, sin(pi/2 * k / size) in Q1.15, built from a
	// Q30 Taylor series with the odd terms clamped at zero.
	function automatic logic [15:0] quarter_sine_at(input int unsigned k);
		longint unsigned angle;
		longint unsigned angle_sq;
		longint unsigned term;
		longint unsigned acc;
		longint unsigned divisor;
		angle    = (longint'(k) * HALF_PI_FIX + SINE_TABLE_SIZE / 2) / SINE_TABLE_SIZE;
		angle_sq = (angle * angle + (64'd1 << 29)) >> 30;
		term     = angle;
		acc      = angle;
		for (int n = 1; n <= 10; n++) begin
			divisor = 64'((2 * n) * (2 * n + 1));
			term    = ((term * angle_sq) >> 30) / divisor;
			if (n % 2 == 1) begin
				acc = (term > acc) ? 64'd0 : acc - term;
			end else begin
				acc = acc + term;
			end
		end
		acc = (acc + (64'd1 << 14)) >> 15;
		return (acc > 64'd32768) ? 16'd32768 : acc[15:0];
	endfunction

	// sin(x * pi/2) for x = pos / 65536, linearly interpolated between table entries.
	function automatic longint unsigned pan_sine(input longint unsigned pos);
		longint unsigned scaled;
		longint unsigned idx;
		longint unsigned frac;
		longint unsigned lo;
		longint unsigned hi;
		scaled = pos * SINE_TABLE_SIZE;
		idx    = scaled >> 16;
		frac   = scaled & 64'hFFFF;
		if (idx >= SINE_TABLE_SIZE) begin
			return 64'(quarter_wave[SINE_TABLE_SIZE]);
		end
		lo = 64'(quarter_wave[idx]);
		hi = 64'(quarter_wave[idx + 1]);
		if (hi <= lo) begin
			return lo;
		end
		return lo + (((hi - lo) * frac + 64'd32768) >> 16);
	endfunction

	// One step of the one-pole smoother; the step size rounds half up in magnitude.
	function automatic logic [31:0] step_toward(input logic [31:0] g, input logic [31:0] target,
			input logic [COEF_W-1:0] c);
		longint unsigned delta;
		if (target >= g) begin
			delta = ((64'(target - g) * 64'(c)) + 64'd32768) >> 16;
			return g + delta[31:0];
		end
		delta = ((64'(g - target) * 64'(c)) + 64'd32768) >> 16;
		return g - delta[31:0];
	endfunction

	// Scales one sample by a Q2.30 gain, rounding away from zero and clamping to the sample
	// range. The magnitude seen by the peak meter comes back through level; negative full
	// scale counts as the largest positive value there.
	function automatic logic [SAMPLE_WIDTH-1:0] scale_sample(
			input logic signed [SAMPLE_WIDTH-1:0] s, input logic [31:0] g,
			output logic [PEAK_W-1:0] level);
		longint          wide;
		longint unsigned size;
		longint unsigned r;
		longint unsigned bits;
		wide = longint'(s);
		size = (wide < 0) ? -wide : wide;
		r    = (size * 64'(g) + (64'd1 << 29)) >> 30;
		if (wide < 0) begin
			if (r > POS_LIMIT + 1) begin
				r = POS_LIMIT + 1;
			end
			level = (r > POS_LIMIT) ? POS_LIMIT[PEAK_W-1:0] : r[PEAK_W-1:0];
			bits  = 64'd0 - r;
			return bits[SAMPLE_WIDTH-1:0];
		end
		if (r > POS_LIMIT) begin
			r = POS_LIMIT;
		end
		level = r[PEAK_W-1:0];
		return r[SAMPLE_WIDTH-1:0];
	endfunction

	// Works out the scaled frame for one accepted input beat and advances the bench state.
	function automatic result_t scale_frame(input frame_t f);
		result_t           out;
		logic [15:0]       vol;
		logic [COEF_W-1:0] c;
		logic [31:0]       target_l;
		logic [31:0]       target_r;
		longint unsigned   pos;
		longint unsigned   wide;
		logic [PEAK_W-1:0] level;
		vol = set_muted ? 16'd0 : set_volume;
		c   = (set_coeff > COEFF_ONE) ? COEFF_ONE : set_coeff;
		if (set_stereo) begin
			// Pan plus one half of full scale is the pan word with its sign bit flipped.
			pos      = {48'd0, ~set_pan[15], set_pan[14:0]};
			wide     = (64'(vol) * pan_sine(64'd65536 - pos)) << 1;
			target_l = wide[31:0];
			wide     = (64'(vol) * pan_sine(pos)) << 1;
			target_r = wide[31:0];
		end else begin
			target_l = {vol, 16'd0};
			target_r = target_l;
		end
		if (!gains_primed) begin
			left_gain    = target_l;
			right_gain   = target_r;
			gains_primed = 1'b1;
		end
		left_gain    = step_toward(left_gain, target_l, c);
		out.left_out = scale_sample(f.left_in, left_gain, level);
		if (level > block_peak) begin
			block_peak = level;
		end
		if (set_stereo) begin
			right_gain    = step_toward(right_gain, target_r, c);
			out.right_out = scale_sample(f.right_in, right_gain, level);
			if (level > block_peak) begin
				block_peak = level;
			end
		end else begin
			// Mono leaves the right smoother where it stands.
			out.right_out = '0;
		end
		out.peak_level = block_peak;
		out.block_done = f.last_in_block;
		if (f.last_in_block) begin
			block_peak = '0;
		end
		return out;
	endfunction

	// ------------------------------------------------------------------
	// Result checking.
	// ------------------------------------------------------------------

	function automatic void report_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
	endfunction

	// The receiver stalls at random; the stall changes only at the falling edge.
	always @(negedge clk) begin
		result_stall = !calm && ($urandom_range(99) < IDLE_PCT);
	end

	// Every result beat is compared field by field with the oldest frame still due.
	always @(posedge clk) begin : check_results
		result_t due;
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (scaled_frames_due.size() == 0) begin
				report_failure($sformatf("result beat with nothing due, left_out %0d",
					result.left_out));
			end else begin
				due = scaled_frames_due.pop_front();
				if (result.left_out !== due.left_out) begin
					report_failure($sformatf("left_out expected %0d, got %0d",
						due.left_out, result.left_out));
				end
				if (result.right_out !== due.right_out) begin
					report_failure($sformatf("right_out expected %0d, got %0d",
						due.right_out, result.right_out));
				end
				if (result.peak_level !== due.peak_level) begin
					report_failure($sformatf("peak_level expected %0d, got %0d",
						due.peak_level, result.peak_level));
				end
				if (result.block_done !== due.block_done) begin
					report_failure($sformatf("block_done expected %0b, got %0b",
						due.block_done, result.block_done));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Channel drivers. All inputs change at the falling edge only.
	// ------------------------------------------------------------------

	// Sends one frame beat. Valid is left high on return so that a following call can keep
	// the channel busy; a caller that stops sending lowers it with frame_quiet.
	task automatic send_frame(input frame_t f);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			frame_valid = 1'b0;
			@(negedge clk);
		end
		frame_valid = 1'b1;
		frame       = f;
		do @(posedge clk); while (frame_stall !== 1'b0);
		scaled_frames_due.push_back(scale_frame(f));
	endtask

	task automatic frame_quiet();
		@(negedge clk);
		frame_valid = 1'b0;
	endtask

	// Stops sending and waits until every frame due has come back, so that the block is idle.
	task automatic settle();
		frame_quiet();
		while (scaled_frames_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Writes one register and mirrors the write into the bench copy.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_VOLUME: set_volume = data[15:0];
			REG_MUTED:  set_muted  = data[0];
			REG_PAN:    set_pan    = data[15:0];
			REG_COEFF:  set_coeff  = data;
			REG_STEREO: set_stereo = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic frame_t frame_of(input logic signed [SAMPLE_WIDTH-1:0] l,
			input logic signed [SAMPLE_WIDTH-1:0] r, input logic last);
		frame_t f;
		f.left_in       = l;
		f.right_in      = r;
		f.last_in_block = last;
		return f;
	endfunction

	// ------------------------------------------------------------------
	// Random choices. Extremes come up often on purpose.
	// ------------------------------------------------------------------

	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
		logic signed [SAMPLE_WIDTH-1:0] s;
		s = SAMPLE_WIDTH'($urandom);
		case ($urandom_range(9))
			0: s = FULL_POS;
			1: s = FULL_NEG;
			2: s = '0;
			3: s = '1;
			default: ;
		endcase
		return s;
	endfunction

	// Each register picked (all if every is set) gets fresh data; bits above its width are random too.
	task automatic shuffle_settings(input bit every);
		logic [CFG_DATA_W-1:0] d;
		if (every || $urandom_range(1)) begin
			d = CFG_DATA_W'($urandom);
			case ($urandom_range(4))
				0: d[15:0] = 16'd0;
				1: d[15:0] = 16'hFFFF;
				2: d[15:0] = VOLUME_RST;
				default: ;
			endcase
			write_register(REG_VOLUME, d);
		end
		if (every || $urandom_range(1)) begin
			d    = CFG_DATA_W'($urandom);
			d[0] = ($urandom_range(3) == 0);
			write_register(REG_MUTED, d);
		end
		if (every || $urandom_range(1)) begin
			d = CFG_DATA_W'($urandom);
			case ($urandom_range(4))
				0: d[15:0] = 16'h8000;
				1: d[15:0] = 16'h7FFF;
				2: d[15:0] = 16'h0000;
				default: ;
			endcase
			write_register(REG_PAN, d);
		end
		if (every || $urandom_range(1)) begin
			d = CFG_DATA_W'($urandom);
			case ($urandom_range(7))
				0: d = '0;
				1: d = 17'd1;
				2: d = COEFF_RST;
				3: d = 17'd65535;
				4: d = COEFF_ONE;
				5: d = '1;
				6: d = CFG_DATA_W'($urandom_range(4095));
				default: ;
			endcase
			write_register(REG_COEFF, d);
		end
		if (every || $urandom_range(1)) begin
			d    = CFG_DATA_W'($urandom);
			d[0] = ($urandom_range(3) != 0);
			write_register(REG_STEREO, d);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Reset settings: the first frame primes both smoothers at the target, full-scale
	// samples of both signs pass at the centre-pan gain, and the peak clears after each block.
	task automatic test_reset_defaults();
		send_frame(frame_of('0, '0, 1'b0));
		send_frame(frame_of(FULL_POS, FULL_NEG, 1'b0));
		send_frame(frame_of(FULL_NEG, FULL_POS, 1'b0));
		send_frame(frame_of('1, 24'sd1, 1'b1));
		send_frame(frame_of(24'sd1, '1, 1'b0));
		send_frame(frame_of(FULL_POS, FULL_POS, 1'b1));
		settle();
	endtask

	// Register extremes: hard left and near hard right at the largest volume saturate the
	// output on the panned side, mute drives the targets to zero, a coefficient above one acts as
	// an instant jump and a zero coefficient freezes the gains, mono ignores the right input and
	// holds the right smoother, and a write to an unmapped index changes nothing.
	task automatic test_register_extremes();
		write_register(REG_COEFF, COEFF_ONE);
		write_register(REG_VOLUME, 17'h0FFFF);
		write_register(REG_PAN, 17'h08000);
		send_frame(frame_of(FULL_POS, FULL_NEG, 1'b0));
		send_frame(frame_of(FULL_NEG, FULL_POS, 1'b1));
		settle();

		write_register(REG_PAN, 17'h07FFF);
		send_frame(frame_of(FULL_NEG, FULL_NEG, 1'b0));
		send_frame(frame_of(24'sd12345, -24'sd54321, 1'b1));
		settle();

		write_register(REG_MUTED, 17'd1);
		send_frame(frame_of(FULL_POS, FULL_NEG, 1'b1));
		settle();

		write_register(REG_MUTED, 17'd0);
		write_register(REG_COEFF, '1);
		write_register(REG_VOLUME, {1'b0, VOLUME_RST});
		write_register(REG_PAN, 17'd0);
		send_frame(frame_of(FULL_POS, FULL_NEG, 1'b0));
		settle();

		write_register(REG_COEFF, '0);
		write_register(REG_VOLUME, 17'd0);
		send_frame(frame_of(FULL_NEG, FULL_POS, 1'b0));
		send_frame(frame_of(24'sd4096, -24'sd4096, 1'b1));
		settle();

		write_register(REG_STEREO, 17'd0);
		write_register(REG_COEFF, COEFF_ONE);
		write_register(REG_VOLUME, 17'h0FFFF);
		send_frame(frame_of(FULL_NEG, FULL_POS, 1'b0));
		send_frame(frame_of('1, FULL_POS, 1'b1));
		settle();

		write_register(REG_VOLUME, 17'd0);
		write_register(REG_COEFF, '0);
		send_frame(frame_of(FULL_POS, FULL_NEG, 1'b1));
		settle();

		// Back in stereo the right smoother starts from where mono left it.
		write_register(REG_UNUSED, '1);
		write_register(REG_STEREO, 17'd1);
		write_register(REG_COEFF, COEFF_RST);
		send_frame(frame_of(FULL_POS, FULL_NEG, 1'b1));
		settle();
	endtask

	// Random frames in phases, with new settings between phases. One phase runs with no
	// idling on either side, and in another the sender waits mid-phase until the block has
	// returned everything.
	task automatic test_random_traffic();
		frame_t f;
		for (int ph = 0; ph < RUN_PHASES; ph++) begin
			settle();
			shuffle_settings(ph == 0);
			calm = (ph == CALM_PHASE);
			for (int i = 0; i < PHASE_FRAMES; i++) begin
				if (ph == DRAIN_PHASE && i == PHASE_FRAMES / 2) begin
					settle();
				end
				f.left_in       = pick_sample();
				f.right_in      = pick_sample();
				f.last_in_block = ($urandom_range(7) == 0);
				send_frame(f);
			end
			calm = 1'b0;
		end
		settle();
	endtask

	initial begin
		// Every input is known from time zero, while reset is held low.
		arst_n       = 1'b0;
		frame_valid  = 1'b0;
		frame        = '0;
		result_stall = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;

		for (int k = 0; k <= SINE_TABLE_SIZE; k++) begin
			quarter_wave[k] = quarter_sine_at(k);
		end
		set_volume   = VOLUME_RST;
		set_muted    = 1'b0;
		set_pan      = '0;
		set_coeff    = COEFF_RST;
		set_stereo   = 1'b1;
		left_gain    = '0;
		right_gain   = '0;
		gains_primed = 1'b0;
		block_peak   = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_random_traffic();

		// A late or spurious beat would still show up within this window.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
